// ----- design/slm_pkg.sv -----
// Package for the sorted list merge block: store sizing, command codes,
// record and port word types. No dependencies.
package slm_pkg;

    // Entries held in each of the two record stores
    localparam int LIST_DEPTH = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Command codes
    typedef enum logic [1:0] {
        OP_LOAD_DAILY  = 2'd0,
        OP_LOAD_MASTER = 2'd1,
        OP_MERGE       = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    // One stored record
    typedef struct packed {
        logic [15:0] subject_code;
        logic [15:0] student_id;
        logic [15:0] name_ref;
    } rec_t;

    // Command word
    typedef struct packed {
        op_t         opcode;
        logic [15:0] subject_code;
        logic [15:0] student_id;
        logic [15:0] name_ref;
    } cmd_t;

    // Result word
    typedef struct packed {
        logic [15:0] out_subject_code;
        logic [15:0] out_student_id;
        logic [15:0] out_name_ref;
        logic        from_daily;
        logic        last_record;
    } result_t;

endpackage

// ----- design/sorted_list_merge.sv -----
// Top level of the sorted list merge block: two record stores and the
// merge sequencer. Depends on slm_pkg.

// Loads leave busy low, so a load may follow every cycle. A merge raises
// busy and, for each stored record, steps through a fetch state that reads
// the head entries from the two stores and an emit state that compares them
// and emits a word; its last word (marked by last_record) shows on the cycle
// busy falls. A merge with both stores empty emits nothing and leaves busy low.
// Each result word is shown for exactly one cycle on strobe; the receiver
// cannot stall the block. Loads beyond a full store are dropped, and both
// counts return to zero after every merge.
module sorted_list_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  slm_pkg::cmd_t    cmd,
    output logic             strobe,
    output slm_pkg::result_t result
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [slm_pkg::CNT_W-1:0] d_cnt_reg, d_cnt_next;
    logic [slm_pkg::CNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic [slm_pkg::CNT_W-1:0] d_ptr_reg, d_ptr_next;
    logic [slm_pkg::CNT_W-1:0] m_ptr_reg, m_ptr_next;

    slm_pkg::rec_t daily_mem  [slm_pkg::LIST_DEPTH];
    slm_pkg::rec_t master_mem [slm_pkg::LIST_DEPTH];
    slm_pkg::rec_t d_rd_reg, m_rd_reg;

    slm_pkg::result_t result_reg, result_next;
    logic             strobe_reg, strobe_next;

    logic          accept;
    logic          wr_daily, wr_master;
    slm_pkg::rec_t wr_rec;
    logic          d_left, m_left, take_d, is_last;
    logic [slm_pkg::CNT_W-1:0] d_ptr_inc, m_ptr_inc;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Load decode: drop writes into a full store
    assign wr_rec    = '{subject_code: cmd.subject_code,
                         student_id:   cmd.student_id,
                         name_ref:     cmd.name_ref};
    assign wr_daily  = accept && (cmd.opcode == slm_pkg::OP_LOAD_DAILY)
                       && (d_cnt_reg != slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));
    assign wr_master = accept && (cmd.opcode == slm_pkg::OP_LOAD_MASTER)
                       && (m_cnt_reg != slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));

    // Write on load, read the head entries every cycle
    always_ff @(posedge clk)
    begin
        if (wr_daily)
        begin
            daily_mem[d_cnt_reg[slm_pkg::ADDR_W-1:0]] <= wr_rec;
        end
        if (wr_master)
        begin
            master_mem[m_cnt_reg[slm_pkg::ADDR_W-1:0]] <= wr_rec;
        end
        d_rd_reg <= daily_mem[d_ptr_reg[slm_pkg::ADDR_W-1:0]];
        m_rd_reg <= master_mem[m_ptr_reg[slm_pkg::ADDR_W-1:0]];
    end

    // Pick the head: daily on a strictly smaller code or once master is used up
    assign d_left    = (d_ptr_reg != d_cnt_reg);
    assign m_left    = (m_ptr_reg != m_cnt_reg);
    assign take_d    = d_left && (!m_left || (d_rd_reg.subject_code < m_rd_reg.subject_code));
    assign d_ptr_inc = d_ptr_reg + slm_pkg::CNT_W'(take_d);
    assign m_ptr_inc = m_ptr_reg + slm_pkg::CNT_W'(!take_d);
    assign is_last   = (d_ptr_inc == d_cnt_reg) && (m_ptr_inc == m_cnt_reg);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        d_cnt_next  = d_cnt_reg;
        m_cnt_next  = m_cnt_reg;
        d_ptr_next  = d_ptr_reg;
        m_ptr_next  = m_ptr_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (wr_daily)
                begin
                    d_cnt_next = d_cnt_reg + slm_pkg::CNT_W'(1);
                end
                if (wr_master)
                begin
                    m_cnt_next = m_cnt_reg + slm_pkg::CNT_W'(1);
                end
                if (accept && (cmd.opcode == slm_pkg::OP_MERGE))
                begin
                    d_ptr_next = '0;
                    m_ptr_next = '0;
                    if ((d_cnt_reg != '0) || (m_cnt_reg != '0))
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                if (take_d)
                begin
                    result_next.out_subject_code = d_rd_reg.subject_code;
                    result_next.out_student_id   = d_rd_reg.student_id;
                    result_next.out_name_ref     = d_rd_reg.name_ref;
                end
                else
                begin
                    result_next.out_subject_code = m_rd_reg.subject_code;
                    result_next.out_student_id   = m_rd_reg.student_id;
                    result_next.out_name_ref     = m_rd_reg.name_ref;
                end
                result_next.from_daily  = take_d;
                result_next.last_record = is_last;
                d_ptr_next = d_ptr_inc;
                m_ptr_next = m_ptr_inc;
                if (is_last)
                begin
                    d_cnt_next = '0;
                    m_cnt_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            d_cnt_reg  <= '0;
            m_cnt_reg  <= '0;
            d_ptr_reg  <= '0;
            m_ptr_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            d_cnt_reg  <= d_cnt_next;
            m_cnt_reg  <= m_cnt_next;
            d_ptr_reg  <= d_ptr_next;
            m_ptr_reg  <= m_ptr_next;
            strobe_reg <= strobe_next;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ----- design/slm_checker.sv -----
// Port-level checks for the sorted list merge block, bound to the top level.
// Depends on slm_pkg and sorted_list_merge.
module slm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input slm_pkg::cmd_t    cmd,
    input logic             strobe,
    input slm_pkg::result_t result
);

    // Words of a merge are spaced by the fetch cycle
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("two result words on consecutive cycles");

    // Any word but the last arrives while the merge still runs
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last_record) |-> busy)
        else $error("non-final word outside a merge");

    // Busy drops exactly as the last word shows
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && result.last_record))
        else $error("merge ended without a final word");

    // A load never starts a busy period
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == slm_pkg::OP_LOAD_DAILY ||
                            cmd.opcode == slm_pkg::OP_LOAD_MASTER)) |=> !busy)
        else $error("load made the block busy");

endmodule

bind sorted_list_merge slm_checker u_slm_checker (.*);
